@@ rtl/touch_point_qualify_map_macros.svh @@
// Assertion macros shared by the touch point qualify/map checker.
// Needs nothing else; included by the checker file only.
`ifndef TOUCH_POINT_QUALIFY_MAP_MACROS_SVH
`define TOUCH_POINT_QUALIFY_MAP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TPQM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TPQM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tpqm_pkg.sv @@
// Package for the touch point qualify/map block: beat types, widths,
// qualification thresholds, register indexes and register reset values.
`timescale 1ns / 1ps

package tpqm_pkg;

  localparam int RAW_W      = 12;
  localparam int SX_W       = 8;
  localparam int SY_W       = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int SUM_W      = 14;

  // Press qualification thresholds.
  localparam logic [RAW_W-1:0] Z1_MIN     = 12'd80;
  localparam logic [SUM_W-1:0] FULL_SCALE = 14'd4095;
  localparam logic [SUM_W-1:0] PRESS_MIN  = 14'd350;
  localparam logic [RAW_W-1:0] POS_MIN    = 12'd50;
  localparam logic [RAW_W-1:0] POS_MAX    = 12'd4050;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_X_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_LAST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LAST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES = 3'd4;

  // Register reset values.
  localparam logic [RAW_W-1:0] X_FIRST_RST = 12'd300;
  localparam logic [RAW_W-1:0] X_LAST_RST  = 12'd3800;
  localparam logic [RAW_W-1:0] Y_FIRST_RST = 12'd300;
  localparam logic [RAW_W-1:0] Y_LAST_RST  = 12'd3800;
  localparam logic             SWAP_RST    = 1'b1;

  typedef struct packed {
    logic [RAW_W-1:0] pressure_one;
    logic [RAW_W-1:0] pressure_two;
    logic [RAW_W-1:0] raw_horizontal;
    logic [RAW_W-1:0] raw_vertical;
  } pt_in_t;

  typedef struct packed {
    logic            pressed;
    logic [SX_W-1:0] screen_x;
    logic [SY_W-1:0] screen_y;
  } pt_out_t;

endpackage

@@ rtl/touch_point_qualify_map.sv @@
// Top level of the touch point qualify/map block: press check, axis swap
// and calibrated mapping through a bit-per-stage divider pipeline. Uses tpqm_pkg.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_data) carries one beat per touch
// sample set: pressure z1, z2 and the raw x and y conversions. The result
// channel (out_valid, out_stall, out_data) returns one beat per sample set,
// in order, holding the press flag and the mapped screen column and row.
// The calibration registers are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while no sample set is in flight
// (the block does not enforce this); indexes past the list are ignored.
// QW is the quotient width, the bit width of the larger screen maximum. One
// quotient bit is resolved per divider stage; throughput is one beat per
// cycle while out_stall is low. Every stage has its own valid bit and moves
// when the stage after it is empty or moving, so bubbles close up and a beat
// is taken at the input even while a finished result waits on a stalled
// output. When the receiver stalls and all stages are full, in_stall rises.
// A synchronous reset empties the pipeline and returns the calibration
// registers to their defaults; nothing is lost or repeated across a stall.
module touch_point_qualify_map #(
  parameter int SCREEN_X_MAX = 239,
  parameter int SCREEN_Y_MAX = 319
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tpqm_pkg::pt_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tpqm_pkg::pt_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [tpqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpqm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RW     = tpqm_pkg::RAW_W;
  localparam int MAX_MX = (SCREEN_X_MAX > SCREEN_Y_MAX) ? SCREEN_X_MAX : SCREEN_Y_MAX;
  // Quotient width; a clamped quotient never exceeds the screen maximum.
  localparam int QW     = $clog2(MAX_MX + 1);
  // Product width: a 12-bit distance times a QW-bit maximum.
  localparam int PW     = RW + QW;
  // Stages: front end, multiply, QW divide steps, output register.
  localparam int NS     = QW + 3;
  localparam int EW     = (QW > tpqm_pkg::SY_W) ? QW : tpqm_pkg::SY_W;

  localparam logic [QW-1:0] X_TOP = QW'(SCREEN_X_MAX);
  localparam logic [QW-1:0] Y_TOP = QW'(SCREEN_Y_MAX);

  // Per-axis working record. rem holds the distance, then the product, then
  // the running remainder; dv is the span magnitude.
  typedef struct packed {
    logic          zero;
    logic          sat;
    logic [PW-1:0] rem;
    logic [QW-1:0] quo;
    logic [RW-1:0] dv;
  } axis_t;

  typedef struct packed {
    logic  ok;
    axis_t ax;
    axis_t ay;
  } stage_t;

  // Calibration registers.
  logic [RW-1:0] x_first_r, x_last_r, y_first_r, y_last_r;
  logic          swap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_first_r <= tpqm_pkg::X_FIRST_RST;
      x_last_r  <= tpqm_pkg::X_LAST_RST;
      y_first_r <= tpqm_pkg::Y_FIRST_RST;
      y_last_r  <= tpqm_pkg::Y_LAST_RST;
      swap_r    <= tpqm_pkg::SWAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tpqm_pkg::CFG_X_FIRST:   x_first_r <= cfg_data[RW-1:0];
        tpqm_pkg::CFG_X_LAST:    x_last_r  <= cfg_data[RW-1:0];
        tpqm_pkg::CFG_Y_FIRST:   y_first_r <= cfg_data[RW-1:0];
        tpqm_pkg::CFG_Y_LAST:    y_last_r  <= cfg_data[RW-1:0];
        tpqm_pkg::CFG_SWAP_AXES: swap_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end of one axis. The mapped value is zero whenever the press is
  // rejected, the span is empty, the distance is zero, or distance and span
  // have opposite signs (the truncated quotient is then zero or negative).
  // If the distance magnitude reaches the span magnitude the quotient is at
  // least the maximum, so the axis saturates; otherwise it fits in QW bits.
  function automatic axis_t axis_front(input logic [RW-1:0] raw,
                                       input logic [RW-1:0] lo,
                                       input logic [RW-1:0] hi,
                                       input logic          ok);
    logic [RW:0]   d;
    logic [RW:0]   s;
    logic [RW:0]   d_abs;
    logic [RW:0]   s_abs;
    axis_t         a;
    d     = {1'b0, raw} - {1'b0, lo};
    s     = {1'b0, hi} - {1'b0, lo};
    d_abs = d[RW] ? (~d + 1'b1) : d;
    s_abs = s[RW] ? (~s + 1'b1) : s;
    a.zero = !ok || (s == '0) || (d == '0) || (d[RW] != s[RW]);
    a.sat  = d_abs[RW-1:0] >= s_abs[RW-1:0];
    a.rem  = PW'(d_abs[RW-1:0]);
    a.quo  = '0;
    a.dv   = s_abs[RW-1:0];
    return a;
  endfunction

  function automatic logic [QW-1:0] axis_result(input axis_t a, input logic [QW-1:0] top);
    logic [QW-1:0] r;
    if (a.zero) begin
      r = '0;
    end else if (a.sat) begin
      r = top;
    end else begin
      r = a.quo;
    end
    return r;
  endfunction

  // Pipeline control: a stage takes new data when it is empty or its
  // successor is taking its current contents.
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] en;
  logic [NS-1:0] src_v;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    src_v = {v_r[NS-2:0], in_valid};
    for (int i = 0; i < NS; i++) begin
      v_nxt[i] = en[i] ? src_v[i] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  stage_t st_r   [NS-1];
  stage_t st_nxt [NS-1];

  // Stage 0: press qualification, optional swap, distances and spans.
  logic [RW-1:0]                rx, ry, hx, hy;
  logic [tpqm_pkg::SUM_W-1:0]   press_sum;
  logic                         ok_in;

  always_comb begin
    rx        = in_data.raw_horizontal;
    ry        = in_data.raw_vertical;
    press_sum = tpqm_pkg::SUM_W'(in_data.pressure_one) + tpqm_pkg::FULL_SCALE
                - tpqm_pkg::SUM_W'(in_data.pressure_two);
    ok_in     = (in_data.pressure_one >= tpqm_pkg::Z1_MIN)
                && (press_sum >= tpqm_pkg::PRESS_MIN)
                && (rx >= tpqm_pkg::POS_MIN) && (rx <= tpqm_pkg::POS_MAX)
                && (ry >= tpqm_pkg::POS_MIN) && (ry <= tpqm_pkg::POS_MAX);
    hx        = swap_r ? ry : rx;
    hy        = swap_r ? rx : ry;
    st_nxt[0].ok = ok_in;
    st_nxt[0].ax = axis_front(hx, x_first_r, x_last_r, ok_in);
    st_nxt[0].ay = axis_front(hy, y_first_r, y_last_r, ok_in);
  end

  // Stage 1: distance times screen maximum.
  always_comb begin
    st_nxt[1]        = st_r[0];
    st_nxt[1].ax.rem = PW'(st_r[0].ax.rem[RW-1:0]) * PW'(X_TOP);
    st_nxt[1].ay.rem = PW'(st_r[0].ay.rem[RW-1:0]) * PW'(Y_TOP);
  end

  // Stages 2 .. QW+1: restoring division, one quotient bit per stage,
  // most significant bit first.
  for (genvar i = 2; i < NS - 1; i++) begin : g_div
    localparam int K = QW + 1 - i;
    logic [PW-1:0] dsh_x, dsh_y;
    always_comb begin
      st_nxt[i] = st_r[i-1];
      dsh_x     = PW'(st_r[i-1].ax.dv) << K;
      dsh_y     = PW'(st_r[i-1].ay.dv) << K;
      if (st_r[i-1].ax.rem >= dsh_x) begin
        st_nxt[i].ax.rem = st_r[i-1].ax.rem - dsh_x;
        st_nxt[i].ax.quo = st_r[i-1].ax.quo | (QW'(1) << K);
      end
      if (st_r[i-1].ay.rem >= dsh_y) begin
        st_nxt[i].ay.rem = st_r[i-1].ay.rem - dsh_y;
        st_nxt[i].ay.quo = st_r[i-1].ay.quo | (QW'(1) << K);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS - 1; i++) begin
      if (en[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Output register: pick zero, the maximum or the quotient per axis, then
  // keep the low bits that fit each screen field.
  tpqm_pkg::pt_out_t out_r;
  tpqm_pkg::pt_out_t out_nxt;
  logic [EW-1:0]     ex_x, ex_y;

  always_comb begin
    ex_x             = EW'(axis_result(st_r[NS-2].ax, X_TOP));
    ex_y             = EW'(axis_result(st_r[NS-2].ay, Y_TOP));
    out_nxt.pressed  = st_r[NS-2].ok;
    out_nxt.screen_x = ex_x[tpqm_pkg::SX_W-1:0];
    out_nxt.screen_y = ex_y[tpqm_pkg::SY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];
  assign out_data  = out_r;

endmodule

@@ rtl/tpqm_checker.sv @@
// Port-level checker for touch_point_qualify_map and its bind statement.
// Uses tpqm_pkg and the macros in touch_point_qualify_map_macros.svh.
`timescale 1ns / 1ps
`include "touch_point_qualify_map_macros.svh"

module tpqm_checker #(
  parameter int SCREEN_X_MAX = 239,
  parameter int SCREEN_Y_MAX = 319
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input tpqm_pkg::pt_in_t                in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input tpqm_pkg::pt_out_t               out_data
);

  // A stalled sample set beat stays put until it is taken.
  `TPQM_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_data), "input beat changed while stalled")

  // A stalled result beat stays put.
  `TPQM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")

  // A rejected press carries zero coordinates.
  `TPQM_ASSERT_IMP(a_idle_zero, clk, rst_n, out_valid && !out_data.pressed, (out_data.screen_x == '0) && (out_data.screen_y == '0), "coordinates nonzero without a press")

  // Mapped coordinates stay within the screen.
  `TPQM_ASSERT_IMP(a_in_range, clk, rst_n, out_valid && out_data.pressed, (int'(out_data.screen_x) <= SCREEN_X_MAX) && (int'(out_data.screen_y) <= SCREEN_Y_MAX), "coordinate beyond screen maximum")

  // The pipeline comes out of reset empty.
  `TPQM_ASSERT_IMP(a_reset_empty, clk, rst_n, $rose(rst_n), !out_valid, "result beat present right after reset")

endmodule

bind touch_point_qualify_map tpqm_checker #(
  .SCREEN_X_MAX(SCREEN_X_MAX),
  .SCREEN_Y_MAX(SCREEN_Y_MAX)
) u_tpqm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ bench/tb_touch_point_qualify_map.sv @@
// Self-checking bench for touch_point_qualify_map: press qualification, axis swap
// and calibrated mapping, checked beat by beat against an in-bench predictor.
// Depends on tpqm_pkg and the touch_point_qualify_map RTL; nothing else.
`timescale 1ns / 1ps

// Tracks the calibration registers, predicts the mapped point for each sample
// set the block takes, and compares each returned point with the oldest one.
class touch_map_checker;
  int x_top;
  int y_top;
  logic [tpqm_pkg::RAW_W-1:0] x_first, x_last, y_first, y_last;
  logic swap_axes;
  tpqm_pkg::pt_out_t expected_points[$];
  int unsigned errors;
  int unsigned samples;
  int unsigned presses;
  int unsigned points_checked;

  function new(int x_max, int y_max);
    x_top = x_max;
    y_top = y_max;
    x_first = tpqm_pkg::X_FIRST_RST;
    x_last = tpqm_pkg::X_LAST_RST;
    y_first = tpqm_pkg::Y_FIRST_RST;
    y_last = tpqm_pkg::Y_LAST_RST;
    swap_axes = tpqm_pkg::SWAP_RST;
  endfunction

  // Mirrors a write on the configuration port; unknown indexes change nothing.
  function void write_reg(logic [tpqm_pkg::CFG_IDX_W-1:0] idx,
                          logic [tpqm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tpqm_pkg::CFG_X_FIRST:   x_first = data;
      tpqm_pkg::CFG_X_LAST:    x_last = data;
      tpqm_pkg::CFG_Y_FIRST:   y_first = data;
      tpqm_pkg::CFG_Y_LAST:    y_last = data;
      tpqm_pkg::CFG_SWAP_AXES: swap_axes = data[0];
      default: ;
    endcase
  endfunction

  // Linear map of one raw reading onto 0..top. A reversed calibration gives a
  // negative span, which works out naturally with signed truncating division.
  function int scale_axis(int raw, int lo, int hi, int top);
    int quo;
    if (lo == hi) return 0;
    quo = ((raw - lo) * top) / (hi - lo);
    if (quo < 0) return 0;
    if (quo > top) return top;
    return quo;
  endfunction

  function void note_sample(tpqm_pkg::pt_in_t s);
    tpqm_pkg::pt_out_t want;
    int z1, z2, rx, ry, sx, sy;
    z1 = s.pressure_one;
    z2 = s.pressure_two;
    rx = s.raw_horizontal;
    ry = s.raw_vertical;
    want = '0;
    want.pressed = (z1 >= int'(tpqm_pkg::Z1_MIN)) &&
                   (z1 + int'(tpqm_pkg::FULL_SCALE) - z2 >= int'(tpqm_pkg::PRESS_MIN)) &&
                   (rx >= int'(tpqm_pkg::POS_MIN)) && (rx <= int'(tpqm_pkg::POS_MAX)) &&
                   (ry >= int'(tpqm_pkg::POS_MIN)) && (ry <= int'(tpqm_pkg::POS_MAX));
    if (want.pressed) begin
      sx = scale_axis(swap_axes ? ry : rx, int'(x_first), int'(x_last), x_top);
      sy = scale_axis(swap_axes ? rx : ry, int'(y_first), int'(y_last), y_top);
      want.screen_x = sx[tpqm_pkg::SX_W-1:0];
      want.screen_y = sy[tpqm_pkg::SY_W-1:0];
      presses++;
    end
    samples++;
    expected_points.push_back(want);
  endfunction

  function void check_point(tpqm_pkg::pt_out_t got);
    tpqm_pkg::pt_out_t want;
    if (expected_points.size() == 0) begin
      $error("result beat with nothing pending: pressed=%0d x=%0d y=%0d",
             got.pressed, got.screen_x, got.screen_y);
      errors++;
      return;
    end
    want = expected_points.pop_front();
    points_checked++;
    if (got.pressed !== want.pressed) begin
      $error("pressed mismatch: expected %0d, actual %0d", want.pressed, got.pressed);
      errors++;
    end
    if (got.screen_x !== want.screen_x) begin
      $error("screen_x mismatch: expected %0d, actual %0d", want.screen_x, got.screen_x);
      errors++;
    end
    if (got.screen_y !== want.screen_y) begin
      $error("screen_y mismatch: expected %0d, actual %0d", want.screen_y, got.screen_y);
      errors++;
    end
  endfunction

  function int pending();
    return expected_points.size();
  endfunction
endclass

module tb_touch_point_qualify_map;

  localparam int SCREEN_X_MAX = 239;
  localparam int SCREEN_Y_MAX = 319;
  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 9;
  // The settle window after the last expected beat gives the block's pipeline
  // plenty of margin to empty.
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 98;
  localparam int CYCLE_LIMIT = 200000;

  // One calibration setting. The swap register is written with a full
  // 12-bit word so that only bit 0 is seen to matter.
  typedef struct {
    logic [tpqm_pkg::RAW_W-1:0]      x_first;
    logic [tpqm_pkg::RAW_W-1:0]      x_last;
    logic [tpqm_pkg::RAW_W-1:0]      y_first;
    logic [tpqm_pkg::RAW_W-1:0]      y_last;
    logic [tpqm_pkg::CFG_DATA_W-1:0] swap_word;
  } calibration_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tpqm_pkg::pt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tpqm_pkg::pt_out_t out_data;
  logic cfg_we = 1'b0;
  logic [tpqm_pkg::CFG_IDX_W-1:0] cfg_index = tpqm_pkg::CFG_X_FIRST;
  logic [tpqm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Idling knobs, in percent of cycles, changed between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Bumping hold_kick asks the receiver process for one long hold-off.
  int hold_kick = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int unsigned cycle_count = 0;
  int unsigned blocked_cycles = 0;
  int unsigned phases_run = 0;

  touch_map_checker sb = new(SCREEN_X_MAX, SCREEN_Y_MAX);

  touch_point_qualify_map #(
    .SCREEN_X_MAX(SCREEN_X_MAX),
    .SCREEN_Y_MAX(SCREEN_Y_MAX)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // The receiver. It normally stalls at random at the current rate; after a
  // kick it stalls for a long stretch so that the pipeline fills and the
  // block has to hold off its own input.
  always @(negedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Result monitor. Every beat that leaves the block is checked against the
  // oldest prediction; input back-pressure is counted for the summary.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_point(out_data);
      if (in_valid && in_stall) blocked_cycles++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d points pending.",
               cycle_count, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic tpqm_pkg::pt_in_t make_sample(int z1, int z2, int rx, int ry);
    tpqm_pkg::pt_in_t s;
    s.pressure_one = z1[tpqm_pkg::RAW_W-1:0];
    s.pressure_two = z2[tpqm_pkg::RAW_W-1:0];
    s.raw_horizontal = rx[tpqm_pkg::RAW_W-1:0];
    s.raw_vertical = ry[tpqm_pkg::RAW_W-1:0];
    return s;
  endfunction

  // A reading near one of the qualification thresholds or the rails.
  function automatic logic [tpqm_pkg::RAW_W-1:0] edge_reading();
    int picks[10] = '{0, 1, 49, 50, 79, 80, 4050, 4051, 4094, 4095};
    int pick;
    pick = picks[$urandom_range(0, 9)];
    return pick[tpqm_pkg::RAW_W-1:0];
  endfunction

  // A uniform 12-bit reading between lo and hi.
  function automatic logic [tpqm_pkg::RAW_W-1:0] rand_reading(int lo, int hi);
    int unsigned v;
    v = $urandom_range(lo, hi);
    return v[tpqm_pkg::RAW_W-1:0];
  endfunction

  // Most random beats are well-formed presses with random position; the rest
  // are unconstrained noise, part of it pushed onto the threshold edges.
  function automatic tpqm_pkg::pt_in_t random_sample();
    tpqm_pkg::pt_in_t s;
    logic [63:0] bits;
    int z1;
    bits = {$urandom, $urandom};
    s = bits[$bits(tpqm_pkg::pt_in_t)-1:0];
    if ($urandom_range(0, 99) < 70) begin
      z1 = $urandom_range(int'(tpqm_pkg::Z1_MIN), 4095);
      s.pressure_one = z1[tpqm_pkg::RAW_W-1:0];
      s.pressure_two = rand_reading(0, (z1 + 3745 > 4095) ? 4095 : z1 + 3745);
      s.raw_horizontal = rand_reading(int'(tpqm_pkg::POS_MIN), int'(tpqm_pkg::POS_MAX));
      s.raw_vertical = rand_reading(int'(tpqm_pkg::POS_MIN), int'(tpqm_pkg::POS_MAX));
    end else if ($urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 1) == 1) s.pressure_one = edge_reading();
      if ($urandom_range(0, 1) == 1) s.pressure_two = edge_reading();
      if ($urandom_range(0, 1) == 1) s.raw_horizontal = edge_reading();
      if ($urandom_range(0, 1) == 1) s.raw_vertical = edge_reading();
    end
    return s;
  endfunction

  function automatic calibration_t random_calibration();
    calibration_t c;
    c.x_first = rand_reading(0, 4095);
    c.x_last = rand_reading(0, 4095);
    c.y_first = rand_reading(0, 4095);
    c.y_last = rand_reading(0, 4095);
    c.swap_word = rand_reading(0, 4095);
    return c;
  endfunction

  // All driving tasks start and end just after a falling edge.
  task automatic write_reg(input logic [tpqm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpqm_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_calibration(input calibration_t c);
    write_reg(tpqm_pkg::CFG_X_FIRST, c.x_first);
    write_reg(tpqm_pkg::CFG_X_LAST, c.x_last);
    write_reg(tpqm_pkg::CFG_Y_FIRST, c.y_first);
    write_reg(tpqm_pkg::CFG_Y_LAST, c.y_last);
    write_reg(tpqm_pkg::CFG_SWAP_AXES, c.swap_word);
  endtask

  // Offers one sample set, idling first at the current rate, and holds the
  // beat steady until the block takes it.
  task automatic send_sample(input tpqm_pkg::pt_in_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data <= random_sample();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  // Waits until every predicted point has come back, then lets the pipeline
  // settle so a stray extra beat would still be caught.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Edges of the pressure and position windows, then mapping at and beyond
  // the reset calibration (swap on, 300..3800 on both axes).
  task automatic send_corner_cases();
    send_sample(make_sample(79, 0, 2000, 2000));      // z1 just under its floor
    send_sample(make_sample(80, 0, 2000, 2000));      // z1 at its floor
    send_sample(make_sample(80, 3826, 2000, 2000));   // pressure sum one short
    send_sample(make_sample(80, 3825, 2000, 2000));   // pressure sum exactly met
    send_sample(make_sample(4095, 4095, 2000, 2000));
    send_sample(make_sample(0, 4095, 2000, 2000));
    send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(4095, 4095, 4095, 4095));
    send_sample(make_sample(1000, 500, 49, 2000));
    send_sample(make_sample(1000, 500, 50, 2000));
    send_sample(make_sample(1000, 500, 4050, 2000));
    send_sample(make_sample(1000, 500, 4051, 2000));
    send_sample(make_sample(1000, 500, 2000, 49));
    send_sample(make_sample(1000, 500, 2000, 50));
    send_sample(make_sample(1000, 500, 2000, 4050));
    send_sample(make_sample(1000, 500, 2000, 4051));
    send_sample(make_sample(1000, 500, 300, 3800));   // both calibration ends
    send_sample(make_sample(1000, 500, 3800, 300));
    send_sample(make_sample(1000, 500, 299, 4000));   // below first, past last
    send_sample(make_sample(1000, 500, 1234, 2345));
    send_sample(make_sample(2730, 1365, 2050, 1050));
  endtask

  // One phase: idling pattern picked from the phase number, optional long
  // receiver hold-off, a run of random sample sets, then a full drain.
  task automatic run_phase(input bit hold_off);
    case (phases_run % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
    if (hold_off) hold_kick++;
    repeat (ITEMS_PER_PHASE) send_sample(random_sample());
    in_valid <= 1'b0;
    wait_drained();
    phases_run++;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset calibration first, directed corners with no idling.
    send_corner_cases();
    run_phase(1'b0);

    // Full-scale calibration, swap cleared by a word whose bit 0 is low.
    apply_calibration('{x_first: 12'd0, x_last: 12'd4095, y_first: 12'd0,
                        y_last: 12'd4095, swap_word: 12'hFFE});
    run_phase(1'b0);

    // Reversed calibration on both axes, swap set again.
    apply_calibration('{x_first: 12'd4095, x_last: 12'd0, y_first: 12'd3900,
                        y_last: 12'd200, swap_word: 12'h001});
    run_phase(1'b0);

    // Equal first and last on x, so every press maps to column zero.
    apply_calibration('{x_first: 12'd2048, x_last: 12'd2048, y_first: 12'd100,
                        y_last: 12'd4000, swap_word: 12'h001});
    run_phase(1'b0);

    // One-count spans make almost every press clamp to an edge. This phase
    // also carries the long receiver hold-off.
    apply_calibration('{x_first: 12'd2000, x_last: 12'd2001, y_first: 12'd2000,
                        y_last: 12'd1999, swap_word: 12'h000});
    run_phase(1'b1);

    apply_calibration(random_calibration());
    run_phase(1'b0);
    apply_calibration(random_calibration());
    run_phase(1'b0);

    // Both axes collapsed at zero, then writes past the register list that
    // must leave everything as it is.
    apply_calibration('{x_first: 12'd0, x_last: 12'd0, y_first: 12'd0,
                        y_last: 12'd0, swap_word: 12'h000});
    for (int i = int'(tpqm_pkg::CFG_SWAP_AXES) + 1; i < (1 << tpqm_pkg::CFG_IDX_W); i++) begin
      write_reg(i[tpqm_pkg::CFG_IDX_W-1:0], 12'hFFF);
    end
    run_phase(1'b0);

    wait_drained();
    if (sb.pending() != 0) begin
      $error("%0d predicted points never came back", sb.pending());
      sb.errors += sb.pending();
    end

    $display("Ran %0d sample sets (%0d pressed) across %0d calibration phases and four idling",
             sb.samples, sb.presses, phases_run);
    $display("patterns; %0d points checked, input held off for %0d cycles.",
             sb.points_checked, blocked_cycles);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
